### design/bspr_pkg.sv
// Shared package of the byte-stuffed packet receiver.
// Holds the line codes, address filter masks, the CRC-8 step function
// and the control structure passed to the CRC unit. No dependencies.
package bspr_pkg;

  // Line codes.
  localparam logic [7:0] BYTE_SOF     = 8'h00;  // start of frame
  localparam logic [7:0] BYTE_ESC     = 8'h80;  // escape prefix
  localparam logic [7:0] BYTE_ESC_SOF = 8'h81;  // escaped 0x00
  localparam logic [7:0] BYTE_ESC_ESC = 8'h82;  // escaped 0x80

  // Address filter masks.
  localparam logic [7:0] ADDR_INST_MASK  = 8'h0F;
  localparam logic [7:0] ADDR_CLASS_MASK = 8'hF0;
  localparam logic [7:0] ADDR_ALL        = 8'hFF;

  // CRC-8, reflected polynomial, worked a few bits per clock.
  localparam logic [7:0] CRC_POLY           = 8'h8C;
  localparam int         CRC_BITS_PER_CYCLE = 2;
  localparam int         CRC_CYCLES         = 8 / CRC_BITS_PER_CYCLE;

  // Payload counter: six bits, saturating at all ones on rejected frames.
  localparam int         COUNT_W   = 6;
  localparam logic [5:0] COUNT_MAX = 6'h3F;

  // Configuration register indexes.
  localparam int         CFG_IDX_W       = 2;
  localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SNIFF_MODE  = 2'd1;
  localparam logic [1:0] CFG_IGNORE_CRC  = 2'd2;

  // Command to the CRC unit.
  typedef struct packed {
    logic       start;   // fold a new byte into the CRC
    logic       clear;   // start from zero instead of the running value
    logic [7:0] value;   // plain byte to fold in
  } crc_cmd_t;

  // One step of the bit-serial CRC: a few shift-and-reduce rounds.
  function automatic logic [7:0] crc_step(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    for (int k = 0; k < CRC_BITS_PER_CYCLE; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### design/bspr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/bspr_crc_unit.sv
// Shared bit-serial CRC-8 unit of the packet receiver.
// Folds one byte into the running CRC in steps, with busy high until the last one; uses bspr_pkg.
module bspr_crc_unit (
  input  logic               clk,
  input  logic               rst,
  input  bspr_pkg::crc_cmd_t cmd,
  output logic [7:0]         crc,
  output logic               busy
);
  import bspr_pkg::*;

  localparam int CNT_W = (CRC_CYCLES > 2) ? $clog2(CRC_CYCLES) : 1;

  logic [CNT_W-1:0] steps_left;
  logic [7:0]       crc_base;

  assign crc_base = cmd.clear ? 8'h00 : crc;
  assign busy     = (steps_left != '0);

  // The first step runs in the cycle the byte arrives; the rest follow.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= 8'h00;
      steps_left <= '0;
    end else if (cmd.start) begin
      crc        <= crc_step(crc_base ^ cmd.value);
      steps_left <= CNT_W'(CRC_CYCLES - 1);
    end else if (busy) begin
      crc        <= crc_step(crc);
      steps_left <= steps_left - 1'b1;
    end
  end

endmodule

### design/byte_stuffed_packet_receiver_unit.sv
// Byte-stuffed packet receiver: frame parser, address filter and emitter.
// Depends on bspr_pkg, bspr_crc_unit and bspr_ram.
//
// Usage:
// Line bytes enter on rx_byte with in_valid; a beat is taken when in_valid
// is high and in_stall is low. 0x00 restarts a frame, 0x80 escapes the next
// 0x81 or 0x82. Header bytes, and payload bytes of a frame that is still
// wanted, stall the input: the shared CRC unit folds two bits per clock
// and in_stall stays high until it is done. Bytes seen outside a frame,
// escape bytes, start-of-frame bytes, payload bytes of a rejected frame
// and the CRC byte do not use the CRC unit. For a good frame the CRC byte
// starts the emitter, which reads the payload memory through its read and
// load states, one byte per result; an empty packet gives a single result
// with has_data low. in_stall stays high until the last result has been
// loaded into the output register. The output register holds its beat
// while out_stall is high, and the emitter waits on it.
// Reset (rst, synchronous) returns the parser to idle, clears the escape,
// empties the output register and loads own_address 1, sniff_mode 0 and
// ignore_crc 0. Configuration writes take effect on the next clock.
module byte_stuffed_packet_receiver_unit #(
  parameter int PAYLOAD_CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [bspr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  // line byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    dest_addr,
  output logic [7:0]                    source_addr,
  output logic [4:0]                    payload_length,
  output logic [7:0]                    command_id,
  output logic                          has_data,
  output logic [7:0]                    data_byte,
  output logic [4:0]                    byte_index,
  output logic                          last
);
  import bspr_pkg::*;

  localparam int         AW      = $clog2(PAYLOAD_CAPACITY);
  localparam logic [6:0] CAP_VAL = 7'(PAYLOAD_CAPACITY);
  localparam logic [7:0] LEN_MAX = 8'(PAYLOAD_CAPACITY - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_DEST, PH_SRC, PH_LEN, PH_CMD, PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE, S_READ, S_LOAD
  } state_t;

  // Configuration registers.
  logic [7:0] own_address;
  logic       sniff_mode;
  logic       ignore_crc;

  // Parser state.
  phase_t             rx_phase, rx_phase_next;
  logic               escape_pending, escape_next;
  logic               reject_flag, reject_next;
  logic [COUNT_W-1:0] payload_count, payload_count_next;
  logic [7:0]         hdr_dest, hdr_source, hdr_length, hdr_command;
  logic               hdr_dest_we, hdr_source_we, hdr_length_we, hdr_command_we;

  // Emitter state.
  state_t             state;
  logic [COUNT_W-1:0] emit_idx;
  logic               start_emit;
  logic               emit_has;
  logic               emit_last;

  // Datapath helpers.
  logic       rx_fire;
  logic [7:0] byte_plain;
  logic [7:0] byte_inv;
  logic       dest_ok;
  logic       at_crc;
  logic       crc_ok;
  crc_cmd_t   crc_cmd;
  logic [7:0] crc_value;
  logic       crc_busy;
  logic       ram_wr_en;
  logic [7:0] ram_rd_data;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'h01;
      sniff_mode  <= 1'b0;
      ignore_crc  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OWN_ADDRESS: own_address <= cfg_data;
        CFG_SNIFF_MODE:  sniff_mode  <= cfg_data[0];
        CFG_IGNORE_CRC:  ignore_crc  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input handshake: a byte is taken only while parser, CRC and emitter are free.
  assign in_stall = (state != S_IDLE) || crc_busy;
  assign rx_fire  = in_valid && !in_stall;

  // Escape decoding and per-byte helpers.
  always_comb begin
    if (escape_pending && rx_byte == BYTE_ESC_SOF) begin
      byte_plain = BYTE_SOF;
    end else if (escape_pending && rx_byte == BYTE_ESC_ESC) begin
      byte_plain = BYTE_ESC;
    end else begin
      byte_plain = rx_byte;
    end
  end

  assign byte_inv = ~byte_plain;
  assign dest_ok  = sniff_mode
                 || (byte_plain == own_address)
                 || (byte_plain == ADDR_ALL)
                 || (((byte_plain & ADDR_INST_MASK) == ADDR_INST_MASK)
                     && ((byte_plain & ADDR_CLASS_MASK)
                         == (own_address & ADDR_CLASS_MASK)));
  assign at_crc   = ({2'b00, payload_count} >= hdr_length);
  assign crc_ok   = ignore_crc || (crc_value == byte_plain);

  // Frame parser: next values of the parser state for an accepted byte.
  always_comb begin
    rx_phase_next      = rx_phase;
    escape_next        = escape_pending;
    reject_next        = reject_flag;
    payload_count_next = payload_count;
    hdr_dest_we        = 1'b0;
    hdr_source_we      = 1'b0;
    hdr_length_we      = 1'b0;
    hdr_command_we     = 1'b0;
    crc_cmd            = '0;
    ram_wr_en          = 1'b0;
    start_emit         = 1'b0;
    if (rx_fire) begin
      if (rx_byte == BYTE_SOF) begin
        rx_phase_next = PH_DEST;
        escape_next   = 1'b0;
        reject_next   = 1'b0;
      end else if (rx_byte == BYTE_ESC) begin
        escape_next = 1'b1;
      end else begin
        escape_next = 1'b0;
        case (rx_phase)
          PH_DEST: begin
            reject_next   = !dest_ok;
            hdr_dest_we   = 1'b1;
            crc_cmd       = '{start: 1'b1, clear: 1'b1, value: byte_plain};
            rx_phase_next = PH_SRC;
          end
          PH_SRC: begin
            hdr_source_we = 1'b1;
            crc_cmd       = '{start: 1'b1, clear: 1'b0, value: byte_plain};
            rx_phase_next = PH_LEN;
          end
          PH_LEN: begin
            if (byte_inv > LEN_MAX) begin
              reject_next = 1'b1;
            end
            hdr_length_we = 1'b1;
            crc_cmd       = '{start: 1'b1, clear: 1'b0, value: byte_inv};
            rx_phase_next = PH_CMD;
          end
          PH_CMD: begin
            hdr_command_we     = 1'b1;
            crc_cmd            = '{start: 1'b1, clear: 1'b0, value: byte_inv};
            payload_count_next = '0;
            rx_phase_next      = PH_DATA;
          end
          PH_DATA: begin
            if (at_crc) begin
              // CRC position: emit the packet if it checks out.
              rx_phase_next = PH_IDLE;
              start_emit    = crc_ok && !reject_flag;
            end else if (!reject_flag) begin
              ram_wr_en          = ({1'b0, payload_count} < CAP_VAL);
              payload_count_next = payload_count + 1'b1;
              crc_cmd            = '{start: 1'b1, clear: 1'b0, value: byte_inv};
            end else if (payload_count != COUNT_MAX) begin
              payload_count_next = payload_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Header registers; written before they are read.
  always_ff @(posedge clk) begin
    if (hdr_dest_we) begin
      hdr_dest <= byte_plain;
    end
    if (hdr_source_we) begin
      hdr_source <= byte_plain;
    end
    if (hdr_length_we) begin
      hdr_length <= byte_inv;
    end
    if (hdr_command_we) begin
      hdr_command <= byte_inv;
    end
  end

  // Emitter flags for the result being loaded.
  assign emit_has  = (hdr_length != 8'h00);
  assign emit_last = !emit_has || (({2'b00, emit_idx} + 8'd1) == hdr_length);

  // Parser state, emitter sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase       <= PH_IDLE;
      escape_pending <= 1'b0;
      reject_flag    <= 1'b0;
      payload_count  <= '0;
      state          <= S_IDLE;
      emit_idx       <= '0;
      out_valid      <= 1'b0;
    end else begin
      rx_phase       <= rx_phase_next;
      escape_pending <= escape_next;
      reject_flag    <= reject_next;
      payload_count  <= payload_count_next;
      // In the load state the output register is either refilled or held.
      if (out_valid && !out_stall && (state != S_LOAD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start_emit) begin
            emit_idx <= '0;
            state    <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // Load the next beat once the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            dest_addr      <= hdr_dest;
            source_addr    <= hdr_source;
            payload_length <= hdr_length[4:0];
            command_id     <= hdr_command;
            has_data       <= emit_has;
            data_byte      <= emit_has ? ram_rd_data : 8'h00;
            byte_index     <= emit_has ? emit_idx[4:0] : 5'd0;
            last           <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Shared CRC unit.
  bspr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .crc  (crc_value),
    .busy (crc_busy)
  );

  // Payload memory.
  bspr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_CAPACITY)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (payload_count[AW-1:0]),
    .wr_data (byte_inv),
    .rd_en   (state == S_READ),
    .rd_addr (emit_idx[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // A byte is never taken while the CRC unit is still folding the last one.
  a_no_accept_crc_busy: assert property (@(posedge clk) disable iff (rst)
    crc_busy |-> in_stall)
    else $error("input beat accepted while CRC unit busy");

  // A result other than the last one implies the emitter is still running.
  a_emit_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state != S_IDLE))
    else $error("emitter idle before last result");

  // Payload writes stay inside the announced length.
  a_write_in_length: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> ({2'b00, payload_count} < hdr_length))
    else $error("payload write beyond frame length");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

### tb/bspr_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the byte-stuffed packet receiver testbench.
// Watches the line, result and register ports, predicts packets and compares them.
// Depends on bspr_pkg for the line codes, polynomial and register indexes.
module bspr_result_checker #(
  parameter int CAPACITY = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bspr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     dest_addr,
  input  logic [7:0]                     source_addr,
  input  logic [4:0]                     payload_length,
  input  logic [7:0]                     command_id,
  input  logic                           has_data,
  input  logic [7:0]                     data_byte,
  input  logic [4:0]                     byte_index,
  input  logic                           last,
  output int                             failures,
  output int                             pending
);
  import bspr_pkg::*;

  localparam int SW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    PH_IDLE, PH_DEST, PH_SRC, PH_LEN, PH_CMD, PH_DATA
  } frame_phase_t;

  typedef struct packed {
    logic [7:0] dest;
    logic [7:0] src;
    logic [4:0] len;
    logic [7:0] cmd;
    logic       has;
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
  } packet_beat_t;

  // Register copies.
  logic [7:0]   node_addr;
  logic         sniff_on;
  logic         crc_off;

  // Parser state.
  frame_phase_t phase;
  logic         esc_armed;
  logic         drop_frame;
  logic [7:0]   crc_acc;
  logic [5:0]   count;
  logic [7:0]   dest_q, src_q, len_q, cmd_q;
  logic [7:0]   store [CAPACITY];

  packet_beat_t packet_beats_q[$];

  // Fold one plain byte into the CRC, a bit at a time.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] r;
    r = crc ^ v;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Exact match, class broadcast or all-broadcast.
  function automatic logic dest_accepted(input logic [7:0] a);
    return ((a & ADDR_INST_MASK) == ADDR_INST_MASK &&
            (a & ADDR_CLASS_MASK) == (node_addr & ADDR_CLASS_MASK)) ||
           a == ADDR_ALL || a == node_addr;
  endfunction

  function automatic packet_beat_t make_beat(input logic has, input logic [7:0] data,
                                             input logic [4:0] idx, input logic fin);
    packet_beat_t r;
    r.dest = dest_q;
    r.src  = src_q;
    r.len  = len_q[4:0];
    r.cmd  = cmd_q;
    r.has  = has;
    r.data = data;
    r.idx  = idx;
    r.last = fin;
    return r;
  endfunction

  // Advance the parser by one line byte and queue the packet beats it releases.
  task automatic decode_line_byte(input logic [7:0] raw);
    logic [7:0] b;
    logic [7:0] v;
    b = raw;
    if (b == BYTE_SOF) begin
      phase = PH_DEST;
      esc_armed = 1'b0;
      drop_frame = 1'b0;
    end else if (b == BYTE_ESC) begin
      esc_armed = 1'b1;
    end else begin
      if (esc_armed && b == BYTE_ESC_SOF) b = BYTE_SOF;
      else if (esc_armed && b == BYTE_ESC_ESC) b = BYTE_ESC;
      esc_armed = 1'b0;
      case (phase)
        PH_DEST: begin
          drop_frame = !(sniff_on || dest_accepted(b));
          dest_q = b;
          crc_acc = crc_fold(8'h00, b);
          phase = PH_SRC;
        end
        PH_SRC: begin
          src_q = b;
          crc_acc = crc_fold(crc_acc, b);
          phase = PH_LEN;
        end
        PH_LEN: begin
          v = ~b;
          if (v > 8'(CAPACITY - 1)) drop_frame = 1'b1;
          len_q = v;
          crc_acc = crc_fold(crc_acc, v);
          phase = PH_CMD;
        end
        PH_CMD: begin
          v = ~b;
          cmd_q = v;
          crc_acc = crc_fold(crc_acc, v);
          count = '0;
          phase = PH_DATA;
        end
        PH_DATA: begin
          if ({2'b00, count} >= len_q) begin
            // CRC position: release the packet if it survived every check.
            phase = PH_IDLE;
            if ((crc_off || crc_acc == b) && !drop_frame) begin
              if (len_q == 8'd0) begin
                packet_beats_q.push_back(make_beat(1'b0, 8'h00, 5'd0, 1'b1));
              end else begin
                for (int i = 0; i < int'(len_q) && i < CAPACITY; i++) begin
                  packet_beats_q.push_back(make_beat(1'b1, store[SW'(i)], 5'(i),
                                                     i + 1 == int'(len_q)));
                end
              end
            end
          end else if (!drop_frame) begin
            v = ~b;
            if (int'(count) < CAPACITY) store[count[SW-1:0]] = v;
            count = count + 6'd1;
            crc_acc = crc_fold(crc_acc, v);
          end else if (count < COUNT_MAX) begin
            count = count + 6'd1;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endtask

  // Compare one result beat with the oldest predicted beat.
  task automatic compare_beat();
    packet_beat_t want;
    if (packet_beats_q.size() == 0) begin
      failures++;
      $display("%0t ns: result beat with nothing expected, expected none, %s %02h data %02h",
               $time, "actual dest", dest_addr, data_byte);
    end else begin
      want = packet_beats_q.pop_front();
      compare_field("dest_addr", want.dest, dest_addr);
      compare_field("source_addr", want.src, source_addr);
      compare_field("payload_length", 8'(want.len), 8'(payload_length));
      compare_field("command_id", want.cmd, command_id);
      compare_field("has_data", 8'(want.has), 8'(has_data));
      compare_field("data_byte", want.data, data_byte);
      compare_field("byte_index", 8'(want.idx), 8'(byte_index));
      compare_field("last", 8'(want.last), 8'(last));
    end
  endtask

  // Sample every port at the clock edge, before the edge's updates land.
  always @(posedge clk) begin
    if (rst) begin
      node_addr = 8'h01;
      sniff_on = 1'b0;
      crc_off = 1'b0;
      phase = PH_IDLE;
      esc_armed = 1'b0;
      drop_frame = 1'b0;
      crc_acc = 8'h00;
      count = '0;
      failures = 0;
      packet_beats_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_OWN_ADDRESS: node_addr = cfg_data;
          CFG_SNIFF_MODE:  sniff_on = cfg_data[0];
          CFG_IGNORE_CRC:  crc_off = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_line_byte(rx_byte);
      if (out_valid && !out_stall) compare_beat();
    end
    pending <= packet_beats_q.size();
  end

endmodule

### tb/byte_stuffed_packet_receiver_unit_test.sv
`timescale 1ns / 100ps
// Top of the byte-stuffed packet receiver testbench: clock, reset, line bytes,
// register writes and result back-pressure. Depends on bspr_pkg, the receiver
// and bspr_result_checker, which does all the prediction and comparing.
module byte_stuffed_packet_receiver_unit_test;
  import bspr_pkg::*;

  localparam int CAPACITY      = 32;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BEATS   = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OWN_ADDRESS;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           dest_addr, source_addr, command_id, data_byte;
  logic [4:0]           payload_length, byte_index;
  logic                 has_data, last;

  int                   failures;
  int                   pending;
  int                   beats_sent = 0;
  int                   cycles = 0;
  int                   hold_left = 0;
  logic                 idle_en = 1'b1;
  logic                 hold_req = 1'b0;
  logic                 hold_done = 1'b0;
  logic [7:0]           node_addr = 8'h01;

  byte_stuffed_packet_receiver_unit #(.PAYLOAD_CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_addr(dest_addr), .source_addr(source_addr), .payload_length(payload_length),
    .command_id(command_id), .has_data(has_data), .data_byte(data_byte),
    .byte_index(byte_index), .last(last)
  );

  bspr_result_checker #(.CAPACITY(CAPACITY)) check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_addr(dest_addr), .source_addr(source_addr), .payload_length(payload_length),
    .command_id(command_id), .has_data(has_data), .data_byte(data_byte),
    .byte_index(byte_index), .last(last),
    .failures(failures), .pending(pending)
  );

  always #4 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result back-pressure: one long hold-off on request, random stalls otherwise while idling is on.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(0, 99) < 9);
    end
  end

  // Plain CRC-8 of a frame, used to build good and bad frames.
  function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] r;
    r = crc ^ v;
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Offer one line byte and hold it until the receiver takes the beat.
  task automatic send_beat(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Send a frame byte with the line codes escaped.
  task automatic send_coded(input logic [7:0] v);
    if (v == BYTE_SOF) begin
      send_beat(BYTE_ESC);
      send_beat(BYTE_ESC_SOF);
    end else if (v == BYTE_ESC) begin
      send_beat(BYTE_ESC);
      send_beat(BYTE_ESC_ESC);
    end else begin
      send_beat(v);
    end
  endtask

  // Whole frame with random payload; oversized lengths carry at most four payload bytes.
  task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                            input logic [7:0] len, input logic [7:0] cmd,
                            input bit bad_crc, input bit cut_short);
    logic [7:0] crc;
    logic [7:0] v;
    int         n;
    n = (int'(len) > CAPACITY - 1) ? int'($urandom_range(0, 4)) : int'(len);
    send_beat(BYTE_SOF);
    send_coded(dest);
    crc = crc_add(8'h00, dest);
    send_coded(src);
    crc = crc_add(crc, src);
    send_coded(~len);
    crc = crc_add(crc, len);
    send_coded(~cmd);
    crc = crc_add(crc, cmd);
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom_range(0, 255));
      send_coded(~v);
      crc = crc_add(crc, v);
    end
    if (!cut_short) send_coded(bad_crc ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc);
  endtask

  // Mostly well-formed frames aimed at the filter cases, some line noise.
  task automatic random_frame();
    logic [7:0] dest;
    logic [7:0] len;
    int         pick;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0, 1:    dest = node_addr;
        2:       dest = {node_addr[7:4], 4'hF};
        3:       dest = ADDR_ALL;
        4:       dest = {~node_addr[7:4], 4'hF};
        default: dest = 8'($urandom_range(0, 255));
      endcase
      pick = int'($urandom_range(0, 99));
      if (pick < 65) len = 8'($urandom_range(0, 6));
      else if (pick < 75) len = 8'(CAPACITY - 1);
      else if (pick < 88) len = 8'($urandom_range(7, CAPACITY - 2));
      else len = 8'($urandom_range(CAPACITY, 255));
      send_frame(dest, 8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                 $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 5);
    end
  endtask

  task automatic run_phase(input int beats);
    int stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_frame();
  endtask

  // Stop sending, let every predicted beat arrive and the parser go quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic sniff, input logic skip_crc);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data <= addr;
    @(posedge clk);
    cfg_index <= CFG_SNIFF_MODE;
    cfg_data <= {7'($urandom_range(0, 127)), sniff};
    @(posedge clk);
    cfg_index <= CFG_IGNORE_CRC;
    cfg_data <= {7'($urandom_range(0, 127)), skip_crc};
    @(posedge clk);
    cfg_write <= 1'b0;
    node_addr = addr;
  endtask

  initial begin
    logic [7:0] crc;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Stray bytes outside a frame are ignored.
    send_beat(8'h55);
    send_beat(BYTE_ESC_ESC);

    // Empty packet to our own address; unescaped 0x81 and 0x82 are plain data.
    crc = crc_add(crc_add(crc_add(crc_add(8'h00, 8'h01), 8'h81), 8'h00), 8'h7D);
    send_beat(BYTE_SOF);
    send_beat(8'h01);
    send_beat(BYTE_ESC_SOF);
    send_beat(8'hFF);
    send_beat(BYTE_ESC_ESC);
    send_coded(crc);

    // Class broadcast with an escape before an ordinary byte, a repeated escape,
    // escaped zero and escaped 0x80, and a zero payload byte.
    crc = crc_add(crc_add(crc_add(crc_add(crc_add(8'h00, 8'h0F), 8'h00), 8'h01), 8'h7F),
                  8'h00);
    send_beat(BYTE_SOF);
    send_beat(BYTE_ESC);
    send_beat(8'h0F);
    send_beat(BYTE_ESC);
    send_beat(BYTE_ESC);
    send_beat(BYTE_ESC_SOF);
    send_beat(8'hFE);
    send_beat(BYTE_ESC);
    send_beat(BYTE_ESC_ESC);
    send_beat(8'hFF);
    send_coded(crc);

    // Oversized length to the all-broadcast address is dropped.
    send_frame(ADDR_ALL, 8'h02, 8'(CAPACITY), 8'h11, 1'b0, 1'b0);

    // Strict filtering and CRC checking, then one long receiver hold-off
    // while a full-size packet and the next frame are offered.
    set_config(8'h3A, 1'b0, 1'b0);
    run_phase(PHASE_BEATS);
    hold_req <= 1'b1;
    send_frame(node_addr, 8'hC3, 8'(CAPACITY - 1), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_frame({node_addr[7:4], 4'hF}, 8'h3C, 8'd3, 8'($urandom_range(0, 255)), 1'b0, 1'b0);

    // Sniffing with the highest address and no idling on either side.
    set_config(8'hFF, 1'b1, 1'b0);
    idle_en <= 1'b0;
    run_phase(PHASE_BEATS);

    // Lowest address with the CRC check off.
    set_config(8'h00, 1'b0, 1'b1);
    idle_en <= 1'b1;
    run_phase(PHASE_BEATS);

    // Sniffing with the CRC check off: every complete frame of legal length is accepted.
    set_config(8'hA5, 1'b1, 1'b1);
    run_phase(PHASE_BEATS);

    wait_drained();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/bspr_pkg.sv
design/bspr_ram.sv
design/bspr_crc_unit.sv
design/byte_stuffed_packet_receiver_unit.sv
tb/bspr_result_checker.sv
tb/byte_stuffed_packet_receiver_unit_test.sv
